@@ hw/rtl/overwrite_ring_fifo_defines.svh @@
// Assertion macros for the overwrite ring FIFO.
// Included by the top level; depends on a signal named clock and one named reset.
`ifndef OVERWRITE_RING_FIFO_DEFINES_SVH
`define OVERWRITE_RING_FIFO_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define ORF_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed in overwrite_ring_fifo");

// The consequent holds in the cycle after the antecedent.
`define ORF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed in overwrite_ring_fifo");

`endif

@@ hw/rtl/orf_pkg.sv @@
// Shared types, constants and helper functions of the overwrite ring FIFO.
// No dependencies; imported by every module of the block.
`default_nettype none
package orf_pkg;
   localparam int DEPTH = 256;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CAP_W = 9;
   localparam int CMD_W = 2;
   localparam int BYTE_W = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_GET   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } orf_cmd_code_type;

   typedef enum logic {
      ORF_IDLE = 1'b0,
      ORF_RESP = 1'b1
   } orf_state_type;

   typedef struct packed {
      logic exec;
      logic cfg_write;
   } orf_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } orf_status_type;

   function automatic logic [IDX_W-1:0] orf_advance(input logic [IDX_W-1:0] idx,
                                                    input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      return (nxt >= cap) ? '0 : IDX_W'(nxt);
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/orf_ram.sv @@
// Byte store of the ring: one write port, one read port with registered data.
// Depends on orf_pkg for depth and widths.
`default_nettype none
module orf_ram
   import orf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output logic      [BYTE_W-1:0] rd_data
);
   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ hw/rtl/orf_ctrl.sv @@
// Handshake controller of the overwrite ring FIFO.
// Depends on orf_pkg for the state and command types.
`default_nettype none
module orf_ctrl
   import orf_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  wire logic   rsp_tready,
   input  wire logic   csr_valid,
   output logic        csr_ready,
   output orf_ctrl_type ctrl
);
   orf_state_type state_ff;
   orf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ORF_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ORF_IDLE: begin
            if (req_tvalid) begin
               state_in = ORF_RESP;
            end
         end
         ORF_RESP: begin
            if (rsp_tready && !req_tvalid) begin
               state_in = ORF_IDLE;
            end
         end
         default: state_in = ORF_IDLE;
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      csr_ready      = 1'b0;
      unique case (state_ff)
         ORF_IDLE: begin
            req_tready = 1'b1;
            csr_ready  = !req_tvalid;
         end
         ORF_RESP: begin
            req_tready = rsp_tready;
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      ctrl.exec      = req_tvalid && req_tready;
      ctrl.cfg_write = csr_valid && csr_ready;
   end
endmodule
`default_nettype wire

@@ hw/rtl/orf_datapath.sv @@
// Ring indices, fill count, capacity register and result registers.
// Depends on orf_pkg and instantiates orf_ram.
`default_nettype none
module orf_datapath
   import orf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire orf_ctrl_type      ctrl,
   input  wire logic [CMD_W-1:0]  cmd,
   input  wire logic [BYTE_W-1:0] write_byte,
   input  wire logic [CAP_W-1:0]  cap_data,
   output logic                   ok,
   output logic      [BYTE_W-1:0] read_byte,
   output logic      [CNT_W-1:0]  fill_count,
   output orf_status_type         status
);
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             full_ff, full_in;
   logic             ok_ff, ok_in;
   logic             got_ff, got_in;
   logic             mem_we, mem_re;
   logic [BYTE_W-1:0] mem_rdata;
   logic [IDX_W-1:0]  wr_adv, rd_adv;
   orf_cmd_code_type  op;

   assign op     = orf_cmd_code_type'(cmd);
   assign wr_adv = orf_advance(wr_ff, cap_ff);
   assign rd_adv = orf_advance(rd_ff, cap_ff);

   always_comb begin
      cap_in  = cap_ff;
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff;
      full_in = full_ff;
      ok_in   = ok_ff;
      got_in  = got_ff;
      mem_we  = 1'b0;
      mem_re  = 1'b0;
      if (ctrl.cfg_write) begin
         if (cap_data == '0) begin
            cap_in = CNT_W'(1);
         end else if (int'(cap_data) > DEPTH) begin
            cap_in = CNT_W'(DEPTH);
         end else begin
            cap_in = CNT_W'(cap_data);
         end
         wr_in   = '0;
         rd_in   = '0;
         cnt_in  = '0;
         full_in = 1'b0;
      end else if (ctrl.exec) begin
         got_in = 1'b0;
         unique case (op)
            CMD_PUT: begin
               mem_we = 1'b1;
               wr_in  = wr_adv;
               if (full_ff) begin
                  rd_in = rd_adv;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               full_in = (wr_adv == (full_ff ? rd_adv : rd_ff));
               ok_in   = !full_in;
            end
            CMD_GET: begin
               if (cnt_ff != '0) begin
                  mem_re  = 1'b1;
                  rd_in   = rd_adv;
                  cnt_in  = cnt_ff - CNT_W'(1);
                  full_in = 1'b0;
                  ok_in   = 1'b1;
                  got_in  = 1'b1;
               end else begin
                  ok_in = 1'b0;
               end
            end
            CMD_CLEAR: begin
               wr_in   = '0;
               rd_in   = '0;
               cnt_in  = '0;
               full_in = 1'b0;
               ok_in   = 1'b1;
            end
            CMD_NONE: begin
               ok_in = 1'b0;
            end
            default: ok_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CNT_W'(DEPTH);
         wr_ff   <= '0;
         rd_ff   <= '0;
         cnt_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         cap_ff  <= cap_in;
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         cnt_ff  <= cnt_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff  <= ok_in;
      got_ff <= got_in;
   end

   orf_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_ff),
      .wr_data (write_byte),
      .rd_en   (mem_re),
      .rd_addr (rd_ff),
      .rd_data (mem_rdata)
   );

   assign ok           = ok_ff;
   assign read_byte    = got_ff ? mem_rdata : '0;
   assign fill_count   = cnt_ff;
   assign status.full  = full_ff;
   assign status.empty = (cnt_ff == '0);
endmodule
`default_nettype wire

@@ hw/rtl/overwrite_ring_fifo.sv @@
// Overwrite ring FIFO: one result per request, ready in the cycle after the transfer.
// A new request is taken in the cycle its predecessor's result is taken, so the
// block sustains one item per cycle while rsp_tready is high; the ring store has
// separate write and read ports and returns read data in the cycle after the transfer.
// Synchronous active-high reset empties the ring and sets the capacity to the full
// depth; store contents are not cleared and no clearing pass is needed.
`default_nettype none
`include "overwrite_ring_fifo_defines.svh"
module overwrite_ring_fifo
   import orf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [BYTE_W-1:0] req_tdata,   // write_byte[7:0]
   input  wire logic [CMD_W-1:0]  req_tuser,   // cmd[1:0]
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [23:0]       rsp_tdata,   // read_byte, fill_count, empty_flag, full_flag
   output logic                   rsp_tuser,   // ok
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CAP_W-1:0]  csr_data
);
   orf_ctrl_type   ctrl;
   orf_status_type status;
   logic              ok;
   logic [BYTE_W-1:0] read_byte;
   logic [CNT_W-1:0]  fill_count;

   orf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .ctrl       (ctrl)
   );

   orf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .cmd        (req_tuser),
      .write_byte (req_tdata),
      .cap_data   (csr_data),
      .ok         (ok),
      .read_byte  (read_byte),
      .fill_count (fill_count),
      .status     (status)
   );

   assign rsp_tdata = {5'd0, status.full, status.empty, 9'(fill_count), read_byte};
   assign rsp_tuser = ok;

   `ORF_ASSERT_NEXT(a_rsp_follows_req, req_tvalid && req_tready, rsp_tvalid)
   `ORF_ASSERT_SAME(a_full_not_empty, status.full, !status.empty)
   `ORF_ASSERT_SAME(a_empty_count, status.empty, fill_count == '0)
   `ORF_ASSERT_SAME(a_no_cfg_busy, rsp_tvalid, !csr_ready)
endmodule
`default_nettype wire
